### hdl/qsse_pkg.sv
// shared types and constants of the quaternion smallest-three encoder
// depends on nothing; every other file imports it

package qsse_pkg;

	localparam int NUM_COMP  = 4;
	localparam int IDX_W     = 2;
	localparam int CODE_W    = 19;
	localparam int TOTAL_W   = 6;
	localparam int LEVEL_W   = 4;
	localparam int WIDTH_W   = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW       = 1'd1;

	localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd11;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;
	localparam logic [WIDTH_W-1:0] LEVEL_BIAS  = 5'd8;

	// settings the datapath sees, derived from the registers
	typedef struct packed {
		logic                raw;
		logic [WIDTH_W-1:0]  width;
		logic [CODE_W-1:0]   top;
	} code_cfg_t;

	// one result word
	typedef struct packed {
		logic [IDX_W-1:0]   largest_index;
		logic               largest_negative;
		logic [CODE_W-1:0]  code_first;
		logic [CODE_W-1:0]  code_second;
		logic [CODE_W-1:0]  code_third;
		logic [TOTAL_W-1:0] total_bits;
	} result_t;

	// round(2^(cb-1) / sqrt(2)) = rounded square root of 2^(2*cb-3), elaboration only
	function automatic longint unsigned qsse_offset(int unsigned cb);
		longint unsigned x;
		longint unsigned r;
		longint unsigned bt;
		longint unsigned xs;
		x  = 64'd1 << (2 * cb - 3);
		xs = x;
		r  = 0;
		bt = 64'd1 << 62;
		while (bt > x)
			bt = bt >> 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		if (xs - r * r > r)
			r = r + 1;
		return r;
	endfunction

endpackage

### hdl/qsse_if.sv
// channel interfaces of the quaternion smallest-three encoder
// depends on qsse_pkg

interface qsse_comp_if import qsse_pkg::*; #(
	parameter int COMPONENT_BITS = 16
);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] comp_0;
	logic signed [COMPONENT_BITS-1:0] comp_1;
	logic signed [COMPONENT_BITS-1:0] comp_2;
	logic signed [COMPONENT_BITS-1:0] comp_3;

	modport source (output valid, comp_0, comp_1, comp_2, comp_3, input ready);
	modport sink (input valid, comp_0, comp_1, comp_2, comp_3, output ready);
endinterface

interface qsse_res_if import qsse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   largest_index;
	logic               largest_negative;
	logic [CODE_W-1:0]  code_first;
	logic [CODE_W-1:0]  code_second;
	logic [CODE_W-1:0]  code_third;
	logic [TOTAL_W-1:0] total_bits;

	modport source (output valid, largest_index, largest_negative, code_first,
		code_second, code_third, total_bits, input ready);
	modport sink (input valid, largest_index, largest_negative, code_first,
		code_second, code_third, total_bits, output ready);
endinterface

interface qsse_cfg_if import qsse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/qsse_lane.sv
// one component lane: magnitude, sign, offset and scale product, raw code
// depends on qsse_pkg

module qsse_lane import qsse_pkg::*; #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  code_cfg_t                        cfg,
	input  logic signed [COMPONENT_BITS-1:0] comp,
	output logic [COMPONENT_BITS-1:0]        mag_s1,
	output logic                             neg_s1,
	output logic signed [COMPONENT_BITS+20:0] prod_s1,
	output logic [CODE_W-1:0]                raw_s1
);
	localparam int CB = COMPONENT_BITS;
	localparam int PW = CB + 21;
	localparam logic signed [CB:0] OFF = (CB+1)'(qsse_offset(CB));

	logic signed [CB:0]     sum;
	logic signed [CODE_W:0] top_s;
	logic [CB+CODE_W-1:0]   raw_ext;

	always_comb begin
		sum     = (CB+1)'(comp) + OFF;
		top_s   = {1'b0, cfg.top};
		raw_ext = {{CODE_W{1'b0}}, comp};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= comp[CB-1] ? (~comp + 1'b1) : comp;
			neg_s1  <= comp[CB-1];
			prod_s1 <= PW'(sum) * PW'(top_s);
			raw_s1  <= raw_ext[CODE_W-1:0];
		end
	end
endmodule

### hdl/qsse_merge.sv
// merge stage: picks the largest lane, finishes the codes, packs the result
// depends on qsse_pkg

module qsse_merge import qsse_pkg::*; #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  code_cfg_t                         cfg,
	input  logic [COMPONENT_BITS-1:0]         mag_s1  [NUM_COMP],
	input  logic                              neg_s1  [NUM_COMP],
	input  logic signed [COMPONENT_BITS+20:0] prod_s1 [NUM_COMP],
	input  logic [CODE_W-1:0]                 raw_s1  [NUM_COMP],
	output result_t                           res_s2
);
	localparam int CB = COMPONENT_BITS;
	localparam int PW = CB + 21;
	localparam int QW = PW - CB;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (CB - 1);
	localparam logic [TOTAL_W-1:0] RAW_TOTAL = TOTAL_W'(3 + 3 * CB);

	logic signed [PW:0]  num  [NUM_COMP];
	logic [QW-1:0]       quot [NUM_COMP];
	logic [CODE_W-1:0]   code [NUM_COMP];
	logic [IDX_W-1:0]    best;
	logic [CB-1:0]       best_mag;
	result_t             res;

	always_comb begin
		// first largest magnitude wins, so only a strictly larger one replaces it
		best     = '0;
		best_mag = mag_s1[0];
		for (int i = 1; i < NUM_COMP; i++) begin
			if (mag_s1[i] > best_mag) begin
				best     = IDX_W'(i);
				best_mag = mag_s1[i];
			end
		end

		for (int i = 0; i < NUM_COMP; i++) begin
			num[i]  = (PW+1)'(prod_s1[i]) + HALF;
			quot[i] = num[i][PW-1:CB];
			if (cfg.raw)
				code[i] = raw_s1[i];
			else if (num[i][PW])
				code[i] = '0;
			else if (quot[i] > QW'(cfg.top))
				code[i] = cfg.top;
			else
				code[i] = quot[i][CODE_W-1:0];
		end

		res.largest_index    = best;
		res.largest_negative = neg_s1[best];
		res.code_first       = (best == 2'd0) ? code[1] : code[0];
		res.code_second      = (best <= 2'd1) ? code[2] : code[1];
		res.code_third       = (best <= 2'd2) ? code[3] : code[2];
		res.total_bits       = cfg.raw ? RAW_TOTAL
			: TOTAL_W'(7'd3 + 7'd3 * 7'(cfg.width));
	end

	always_ff @(posedge clk) begin
		if (en)
			res_s2 <= res;
	end
endmodule

### hdl/quaternion_smallest_three_encoder.sv
// top level of the quaternion smallest-three encoder
// depends on qsse_pkg, qsse_if, qsse_lane and qsse_merge

// Takes one quaternion word per cycle while not stalled (four signed components) and
// returns one result word per quaternion: the index and sign of the first component
// with the largest magnitude, and a code for each of the other three in index order.
// In quantized mode a code has precision_level + 8 bits (level clamped to 1..11) and
// is the component shifted by round(2^(COMPONENT_BITS-1)/sqrt(2)), scaled by 2^b - 1,
// divided by 2^COMPONENT_BITS with rounding to nearest and saturated; in raw mode the
// component words go through. Throughput is one word per clock while not stalled; a
// word passes the lane stage (offset add and scale multiply) and the merge stage
// (largest search, rounding, saturation and selection) into the result register. The
// pipeline stalls as a whole only when both stages are full and the result is not
// taken; a held result never blocks a word entering an empty lane stage. Registers:
// index 0 precision_level (reset 8), index 1 raw_mode (reset 0); the configuration
// channel is always ready and should only be written while idle.

module quaternion_smallest_three_encoder import qsse_pkg::*; #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qsse_cfg_if.sink   cfg,
	qsse_comp_if.sink  comp,
	qsse_res_if.source result
);
	localparam int CB = COMPONENT_BITS;

	// configuration registers
	logic [LEVEL_W-1:0] precision_level_q;
	logic               raw_mode_q;
	logic [LEVEL_W-1:0] level;
	code_cfg_t          code_cfg;

	// pipeline control
	logic valid_s1;
	logic valid_s2;
	logic en1;
	logic en2;

	// lane outputs
	logic signed [CB-1:0]    comp_w  [NUM_COMP];
	logic [CB-1:0]           mag_s1  [NUM_COMP];
	logic                    neg_s1  [NUM_COMP];
	logic signed [CB+20:0]   prod_s1 [NUM_COMP];
	logic [CODE_W-1:0]       raw_s1  [NUM_COMP];
	result_t                 res_s2;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_level_q <= LEVEL_RESET;
			raw_mode_q        <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PRECISION: precision_level_q <= cfg.data;
				REG_RAW:       raw_mode_q        <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// out-of-range levels clamp to the nearest legal one
	always_comb begin
		if (precision_level_q < LEVEL_MIN)
			level = LEVEL_MIN;
		else if (precision_level_q > LEVEL_MAX)
			level = LEVEL_MAX;
		else
			level = precision_level_q;
		code_cfg.raw   = raw_mode_q;
		code_cfg.width = WIDTH_W'(level) + LEVEL_BIAS;
		code_cfg.top   = CODE_W'((20'd1 << code_cfg.width) - 20'd1);
	end

	// stage enables: a stage loads when it is empty or when its successor has room
	assign en2        = !valid_s2 || result.ready;
	assign en1        = !valid_s1 || en2;
	assign comp.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= comp.valid;
			if (en2)
				valid_s2 <= valid_s1;
		end
	end

	assign comp_w[0] = comp.comp_0;
	assign comp_w[1] = comp.comp_1;
	assign comp_w[2] = comp.comp_2;
	assign comp_w[3] = comp.comp_3;

	// one lane per quaternion component
	for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
		qsse_lane #(.COMPONENT_BITS(CB)) u_lane (
			.clk     (clk),
			.en      (en1),
			.cfg     (code_cfg),
			.comp    (comp_w[g]),
			.mag_s1  (mag_s1[g]),
			.neg_s1  (neg_s1[g]),
			.prod_s1 (prod_s1[g]),
			.raw_s1  (raw_s1[g])
		);
	end

	qsse_merge #(.COMPONENT_BITS(CB)) u_merge (
		.clk     (clk),
		.en      (en2),
		.cfg     (code_cfg),
		.mag_s1  (mag_s1),
		.neg_s1  (neg_s1),
		.prod_s1 (prod_s1),
		.raw_s1  (raw_s1),
		.res_s2  (res_s2)
	);

	// result register drives the output word
	assign result.valid            = valid_s2;
	assign result.largest_index    = res_s2.largest_index;
	assign result.largest_negative = res_s2.largest_negative;
	assign result.code_first       = res_s2.code_first;
	assign result.code_second      = res_s2.code_second;
	assign result.code_third       = res_s2.code_third;
	assign result.total_bits       = res_s2.total_bits;
endmodule
